// ===== src/tbp_pkg.sv =====
// Package for the dual token bucket policer.
// Field widths, codes, state types and bucket unit structs; no dependencies.
`timescale 1ns / 1ps

package tbp_pkg;

    localparam int SLOT_W    = 12;
    localparam int COST_W    = 24;
    localparam int TIME_W    = 48;
    localparam int TOK_W     = 31;
    localparam int CFG_W     = 31;
    localparam int CFG_IDX_W = 2;
    localparam int VERDICT_W = 2;

    localparam int SOURCE_SLOTS_DEF = 4096;
    localparam int MS_PER_S         = 1000;

    localparam logic [CFG_W-1:0] GLB_RATE_RST   = CFG_W'(1000000);
    localparam logic [CFG_W-1:0] GLB_BURST_RST  = CFG_W'(1000000);
    localparam logic [CFG_W-1:0] SLOT_RATE_RST  = CFG_W'(100000);
    localparam logic [CFG_W-1:0] SLOT_BURST_RST = CFG_W'(100000);

    // refill arithmetic: elapsed * rate split in two partial products
    localparam int MUL_SPLIT = 24;
    localparam int PP_W      = MUL_SPLIT + TOK_W;
    localparam int PROD_W    = TIME_W + TOK_W;
    localparam int BURST_K_W = TOK_W + 10;
    // restoring divide by 1000, several quotient bits per cycle
    localparam int QUO_W      = 32;
    localparam int REM_W      = 10;
    localparam int DIV_STEPS  = 4;
    localparam int DIV_CYCLES = QUO_W / DIV_STEPS;
    localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

    localparam int WORD_W = TIME_W + TOK_W;

    typedef enum logic [VERDICT_W-1:0] {
        VERDICT_GRANT        = 2'd0,
        VERDICT_SLOT_SHORT   = 2'd1,
        VERDICT_GLOBAL_SHORT = 2'd2
    } t_verdict;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GLB_RATE   = 2'd0,
        CFG_GLB_BURST  = 2'd1,
        CFG_SLOT_RATE  = 2'd2,
        CFG_SLOT_BURST = 2'd3
    } t_cfg_idx;

    typedef enum logic [3:0] {
        B_IDLE,
        B_MUL_LO,
        B_MUL_HI,
        B_SUM,
        B_CMP,
        B_DIV,
        B_APPLY,
        B_CHARGE
    } t_bkt_state;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_SLOT_WAIT,
        S_GLB_WAIT,
        S_FINISH
    } t_ctl_state;

    typedef struct packed {
        logic [TOK_W-1:0]  tokens;
        logic [TIME_W-1:0] last;
        logic [TIME_W-1:0] now;
        logic [COST_W-1:0] cost;
        logic [CFG_W-1:0]  rate;
        logic [CFG_W-1:0]  burst;
    } t_bkt_req;

    typedef struct packed {
        logic [TOK_W-1:0]  tokens;
        logic [TIME_W-1:0] last;
        logic              pass;
    } t_bkt_rsp;

endpackage

// ===== src/tbp_req_if.sv =====
// Request channel: valid/ready plus slot, byte count and time.
// Depends on tbp_pkg for the field widths.
`timescale 1ns / 1ps

interface tbp_req_if;
    logic                        valid;
    logic                        ready;
    logic [tbp_pkg::SLOT_W-1:0]  source_slot;
    logic [tbp_pkg::COST_W-1:0]  pkt_bytes;
    logic [tbp_pkg::TIME_W-1:0]  now_ms;

    modport source (output valid, output source_slot, output pkt_bytes, output now_ms,
                    input ready);
    modport sink   (input valid, input source_slot, input pkt_bytes, input now_ms,
                    output ready);
endinterface

// ===== src/tbp_rsp_if.sv =====
// Result channel: valid/ready plus the verdict.
// Depends on tbp_pkg for the field width.
`timescale 1ns / 1ps

interface tbp_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [tbp_pkg::VERDICT_W-1:0]  verdict;

    modport source (output valid, output verdict, input ready);
    modport sink   (input valid, input verdict, output ready);
endinterface

// ===== src/tbp_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module tbp_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/tbp_bucket.sv =====
// Shared bucket unit: refill from elapsed time, saturate at burst, charge cost.
// Multi-cycle: split multiply, then restoring divide by 1000. Depends on tbp_pkg.
`timescale 1ns / 1ps

module tbp_bucket (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  tbp_pkg::t_bkt_req i_req,
    output logic              o_done,
    output tbp_pkg::t_bkt_rsp o_rsp
);

    localparam int TOK_W  = tbp_pkg::TOK_W;
    localparam int TIME_W = tbp_pkg::TIME_W;
    localparam int QUO_W  = tbp_pkg::QUO_W;
    localparam int REM_W  = tbp_pkg::REM_W;
    localparam int PROD_W = tbp_pkg::PROD_W;
    localparam int SPLIT  = tbp_pkg::MUL_SPLIT;
    localparam int PP_W   = tbp_pkg::PP_W;
    localparam int BK_W   = tbp_pkg::BURST_K_W;
    localparam int CNT_W  = tbp_pkg::DIV_CNT_W;

    tbp_pkg::t_bkt_state r_state, n_state;

    tbp_pkg::t_bkt_req   r_req;
    logic [TIME_W-1:0]   r_elapsed;
    logic                r_back;
    logic                r_equal;
    logic [PP_W-1:0]     r_lo;
    logic [PP_W-1:0]     r_hi;
    logic [BK_W-1:0]     r_burst_k;
    logic [PROD_W-1:0]   r_prod;
    logic                r_sat;
    logic [REM_W-1:0]    r_rem, n_rem;
    logic [QUO_W-1:0]    r_quo, n_quo;
    logic [CNT_W-1:0]    r_cnt;
    logic [TOK_W-1:0]    r_filled, n_filled;
    logic                r_done;
    tbp_pkg::t_bkt_rsp   r_rsp, n_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tbp_pkg::B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tbp_pkg::B_IDLE:   if (i_start) n_state = tbp_pkg::B_MUL_LO;
            tbp_pkg::B_MUL_LO: n_state = tbp_pkg::B_MUL_HI;
            tbp_pkg::B_MUL_HI: n_state = tbp_pkg::B_SUM;
            tbp_pkg::B_SUM:    n_state = tbp_pkg::B_CMP;
            tbp_pkg::B_CMP:    n_state = tbp_pkg::B_DIV;
            tbp_pkg::B_DIV:    if (r_cnt == '0) n_state = tbp_pkg::B_APPLY;
            tbp_pkg::B_APPLY:  n_state = tbp_pkg::B_CHARGE;
            tbp_pkg::B_CHARGE: n_state = tbp_pkg::B_IDLE;
        endcase
    end

    // DIV_STEPS restoring steps on a 10-bit remainder; dividend bits shift out of r_quo
    always_comb begin
        logic [REM_W:0] trial;
        logic           qbit;
        n_rem = r_rem;
        n_quo = r_quo;
        for (int k = 0; k < tbp_pkg::DIV_STEPS; k++) begin
            trial = {n_rem, n_quo[QUO_W-1]};
            qbit  = (trial >= (REM_W+1)'(tbp_pkg::MS_PER_S));
            if (qbit) begin
                trial = trial - (REM_W+1)'(tbp_pkg::MS_PER_S);
            end
            n_rem = trial[REM_W-1:0];
            n_quo = {n_quo[QUO_W-2:0], qbit};
        end
    end

    // refill: time zero or backwards sets full burst, equal time keeps tokens
    always_comb begin
        logic [TOK_W-1:0] refill;
        logic [TOK_W:0]   sum;
        refill = r_sat ? r_req.burst : r_quo[TOK_W-1:0];
        sum    = {1'b0, r_req.tokens} + {1'b0, refill};
        if (r_back) begin
            n_filled = r_req.burst;
        end else if (r_equal) begin
            n_filled = r_req.tokens;
        end else if (sum > {1'b0, r_req.burst}) begin
            n_filled = r_req.burst;
        end else begin
            n_filled = sum[TOK_W-1:0];
        end
    end

    always_comb begin
        logic [TOK_W-1:0] cost;
        cost         = TOK_W'(r_req.cost);
        n_rsp.pass   = (cost <= r_filled);
        n_rsp.tokens = n_rsp.pass ? (r_filled - cost) : r_filled;
        n_rsp.last   = r_req.now;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= (r_state == tbp_pkg::B_CHARGE);
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            tbp_pkg::B_IDLE: begin
                if (i_start) begin
                    r_req     <= i_req;
                    r_elapsed <= i_req.now - i_req.last;
                    r_back    <= (i_req.last == '0) || (i_req.now < i_req.last);
                    r_equal   <= (i_req.now == i_req.last);
                end
            end
            tbp_pkg::B_MUL_LO: begin
                r_lo      <= PP_W'(r_elapsed[SPLIT-1:0]) * PP_W'(r_req.rate);
                r_burst_k <= BK_W'(r_req.burst) * BK_W'(tbp_pkg::MS_PER_S);
            end
            tbp_pkg::B_MUL_HI: begin
                r_hi <= PP_W'(r_elapsed[TIME_W-1:SPLIT]) * PP_W'(r_req.rate);
            end
            tbp_pkg::B_SUM: begin
                r_prod <= PROD_W'(r_lo) + (PROD_W'(r_hi) << SPLIT);
            end
            tbp_pkg::B_CMP: begin
                // product at or above burst*1000 (including past 64 bits) saturates
                r_sat <= (r_prod >= PROD_W'(r_burst_k));
                r_rem <= REM_W'(r_prod[QUO_W+REM_W-2:QUO_W]);
                r_quo <= r_prod[QUO_W-1:0];
                r_cnt <= CNT_W'(tbp_pkg::DIV_CYCLES - 1);
            end
            tbp_pkg::B_DIV: begin
                r_rem <= n_rem;
                r_quo <= n_quo;
                r_cnt <= r_cnt - CNT_W'(1);
            end
            tbp_pkg::B_APPLY: begin
                r_filled <= n_filled;
            end
            tbp_pkg::B_CHARGE: begin
                r_rsp <= n_rsp;
            end
        endcase
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule

// ===== src/dual_token_bucket_policer.sv =====
// Top level of the dual token bucket policer.
// Depends on tbp_pkg, tbp_req_if, tbp_rsp_if, tbp_ram and tbp_bucket.
`timescale 1ns / 1ps

// Usage
//   i_req  : request items (source_slot, pkt_bytes, now_ms), valid/ready.
//   o_rsp  : one verdict item per request: grant, source short, global short.
//   i_cfg_*: register writes (0 global rate, 1 global burst, 2 slot rate,
//            3 slot burst); a written zero acts as 1. Write only while idle.
// Sequencing
//   One request in flight. A granted or global-short request runs both buckets,
//   a source-short one only the slot bucket, an out-of-range slot neither;
//   ready returns the cycle after the verdict is loaded.
//   The shared bucket unit works each bucket in turn (two partial-product
//   multiplies, an add, a compare, a divide by 1000, refill and charge),
//   first the slot bucket and then, if it passes, the global one.
//   Slot buckets live in one RAM (tokens and last refill time per slot); the
//   global bucket sits in registers.
// Reset
//   Synchronous, active low. Afterward a clearing pass zeroes all SOURCE_SLOTS
//   slot RAM entries (4096 by default), one entry a cycle; ready stays low then.
// Stall
//   The verdict sits in an output register; a new request is accepted and
//   worked on while it waits, and only its own verdict waits for the slot.
module dual_token_bucket_policer #(
    parameter int SOURCE_SLOTS = tbp_pkg::SOURCE_SLOTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    tbp_req_if.sink                       i_req,
    tbp_rsp_if.source                     o_rsp,
    input  logic                          i_cfg_we,
    input  logic [tbp_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [tbp_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam int AW     = (SOURCE_SLOTS > 1) ? $clog2(SOURCE_SLOTS) : 1;
    localparam int XW     = (AW > tbp_pkg::SLOT_W) ? AW : tbp_pkg::SLOT_W;
    localparam int TOK_W  = tbp_pkg::TOK_W;
    localparam int TIME_W = tbp_pkg::TIME_W;
    localparam int CFG_W  = tbp_pkg::CFG_W;
    localparam int WORD_W = tbp_pkg::WORD_W;

    // configuration
    logic [CFG_W-1:0] r_glb_rate, r_glb_burst, r_slot_rate, r_slot_burst;
    logic [CFG_W-1:0] cfg_val;

    assign cfg_val = (i_cfg_data == '0) ? CFG_W'(1) : i_cfg_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_glb_rate   <= tbp_pkg::GLB_RATE_RST;
            r_glb_burst  <= tbp_pkg::GLB_BURST_RST;
            r_slot_rate  <= tbp_pkg::SLOT_RATE_RST;
            r_slot_burst <= tbp_pkg::SLOT_BURST_RST;
        end else if (i_cfg_we) begin
            unique case (tbp_pkg::t_cfg_idx'(i_cfg_idx))
                tbp_pkg::CFG_GLB_RATE:   r_glb_rate   <= cfg_val;
                tbp_pkg::CFG_GLB_BURST:  r_glb_burst  <= cfg_val;
                tbp_pkg::CFG_SLOT_RATE:  r_slot_rate  <= cfg_val;
                tbp_pkg::CFG_SLOT_BURST: r_slot_burst <= cfg_val;
            endcase
        end
    end

    // control
    tbp_pkg::t_ctl_state r_state, n_state;
    logic [AW-1:0]       r_clr_addr;
    logic [AW-1:0]       r_addr;
    logic [tbp_pkg::COST_W-1:0] r_cost;
    logic [TIME_W-1:0]   r_now;
    tbp_pkg::t_verdict   r_verdict;
    logic                r_out_valid;
    tbp_pkg::t_verdict   r_out_verdict;
    logic [TOK_W-1:0]    r_glb_tokens;
    logic [TIME_W-1:0]   r_glb_last;

    logic              req_accept;
    logic              in_range;
    logic [XW-1:0]     slot_x;
    logic [AW-1:0]     in_addr;
    logic              out_load;

    logic              ram_we, ram_re;
    logic [AW-1:0]     ram_waddr;
    logic [WORD_W-1:0] ram_wdata, ram_rdata;

    logic              bkt_start, bkt_done;
    tbp_pkg::t_bkt_req bkt_req;
    tbp_pkg::t_bkt_rsp bkt_rsp;

    assign i_req.ready = (r_state == tbp_pkg::S_IDLE);
    assign req_accept  = i_req.valid && i_req.ready;
    assign in_range    = 32'(i_req.source_slot) < 32'(SOURCE_SLOTS);
    assign slot_x      = XW'(i_req.source_slot);
    assign in_addr     = slot_x[AW-1:0];
    assign out_load    = (r_state == tbp_pkg::S_FINISH) && (!r_out_valid || o_rsp.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tbp_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        ram_we    = 1'b0;
        ram_waddr = r_addr;
        ram_wdata = {bkt_rsp.last, bkt_rsp.tokens};
        bkt_start = 1'b0;
        bkt_req   = '{tokens: ram_rdata[TOK_W-1:0], last: ram_rdata[WORD_W-1:TOK_W],
                      now: r_now, cost: r_cost, rate: r_slot_rate, burst: r_slot_burst};
        unique case (r_state)
            tbp_pkg::S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_addr;
                ram_wdata = '0;
                if (r_clr_addr == AW'(SOURCE_SLOTS - 1)) n_state = tbp_pkg::S_IDLE;
            end
            tbp_pkg::S_IDLE: begin
                if (req_accept) begin
                    n_state = in_range ? tbp_pkg::S_READ : tbp_pkg::S_FINISH;
                end
            end
            tbp_pkg::S_READ: begin
                // slot entry arrives this cycle
                bkt_start = 1'b1;
                n_state   = tbp_pkg::S_SLOT_WAIT;
            end
            tbp_pkg::S_SLOT_WAIT: begin
                if (bkt_done) begin
                    ram_we = 1'b1;   // slot charge is kept even if global fails
                    if (bkt_rsp.pass) begin
                        bkt_start = 1'b1;
                        bkt_req   = '{tokens: r_glb_tokens, last: r_glb_last, now: r_now,
                                      cost: r_cost, rate: r_glb_rate, burst: r_glb_burst};
                        n_state   = tbp_pkg::S_GLB_WAIT;
                    end else begin
                        n_state = tbp_pkg::S_FINISH;
                    end
                end
            end
            tbp_pkg::S_GLB_WAIT: begin
                if (bkt_done) n_state = tbp_pkg::S_FINISH;
            end
            tbp_pkg::S_FINISH: begin
                if (out_load) n_state = tbp_pkg::S_IDLE;
            end
        endcase
    end

    assign ram_re = req_accept && in_range;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr   <= '0;
            r_glb_tokens <= '0;
            r_glb_last   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (r_state == tbp_pkg::S_CLEAR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if ((r_state == tbp_pkg::S_GLB_WAIT) && bkt_done) begin
                r_glb_tokens <= bkt_rsp.tokens;
                r_glb_last   <= bkt_rsp.last;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_accept) begin
            r_addr    <= in_addr;
            r_cost    <= i_req.pkt_bytes;
            r_now     <= i_req.now_ms;
            r_verdict <= tbp_pkg::VERDICT_SLOT_SHORT;
        end
        if ((r_state == tbp_pkg::S_SLOT_WAIT) && bkt_done && !bkt_rsp.pass) begin
            r_verdict <= tbp_pkg::VERDICT_SLOT_SHORT;
        end
        if ((r_state == tbp_pkg::S_GLB_WAIT) && bkt_done) begin
            r_verdict <= bkt_rsp.pass ? tbp_pkg::VERDICT_GRANT
                                      : tbp_pkg::VERDICT_GLOBAL_SHORT;
        end
        if (out_load) begin
            r_out_verdict <= r_verdict;
        end
    end

    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.verdict = r_out_verdict;

    tbp_ram #(
        .WIDTH  (WORD_W),
        .DEPTH  (SOURCE_SLOTS),
        .ADDR_W (AW)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (in_addr),
        .o_rdata (ram_rdata)
    );

    tbp_bucket u_bucket (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (bkt_start),
        .i_req   (bkt_req),
        .o_done  (bkt_done),
        .o_rsp   (bkt_rsp)
    );

endmodule

// ===== src/tbp_checker.sv =====
// Port-level checks for the dual token bucket policer, bound to the top level.
// Depends on tbp_pkg and dual_token_bucket_policer.
`timescale 1ns / 1ps

module tbp_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_req_valid,
    input logic                          i_req_ready,
    input logic                          i_rsp_valid,
    input logic                          i_rsp_ready,
    input logic [tbp_pkg::VERDICT_W-1:0] i_rsp_verdict
);

    // a stalled verdict holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_verdict))
        else $error("verdict dropped or changed while stalled");

    // only the three defined verdicts leave the block
    a_rsp_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_rsp_verdict == tbp_pkg::VERDICT_GRANT ||
                         i_rsp_verdict == tbp_pkg::VERDICT_SLOT_SHORT ||
                         i_rsp_verdict == tbp_pkg::VERDICT_GLOBAL_SHORT))
        else $error("undefined verdict code");

    // clearing pass follows reset: no request taken right after it
    a_clear_after_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_req_ready)
        else $error("request ready during slot clearing");

    // one request in flight: busy the cycle after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("second request accepted back to back");

endmodule

bind dual_token_bucket_policer tbp_checker u_tbp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_req_valid   (i_req.valid),
    .i_req_ready   (i_req.ready),
    .i_rsp_valid   (o_rsp.valid),
    .i_rsp_ready   (o_rsp.ready),
    .i_rsp_verdict (o_rsp.verdict)
);
